// ----- rtl/b64e_pkg.sv -----
// Shared types, constants and the sextet-to-character map for the Base64 encoder.
`default_nettype none

package b64e_pkg;

  // ASCII '=' used for padding
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // ASCII anchors of the alphabet ranges
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;

  // Characters per request at most (two sextets plus two pads)
  localparam int unsigned JOB_CHARS = 4;

  // Position within the current three-byte group
  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_ONE   = 2'd1,
    PH_TWO   = 2'd2
  } phase_t;

  // One input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // One result character
  typedef struct packed {
    logic [7:0] out_char;
    logic       message_end;
  } out_item_t;

  // Work handed from front to back: up to four characters for one byte
  typedef struct packed {
    logic [JOB_CHARS-1:0][7:0] chars;
    logic [1:0]                last_idx;  // index of the final character
    logic                      end_flag;  // final character closes the message
  } job_t;

  // Map a 6-bit value onto the standard alphabet
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] ext;
    ext = {2'b00, v};
    case (v) inside
      [6'd0:6'd25]:  return CHAR_UPPER_A + ext;
      [6'd26:6'd51]: return CHAR_LOWER_A + ext - 8'd26;
      [6'd52:6'd61]: return CHAR_ZERO + ext - 8'd52;
      6'd62:         return CHAR_PLUS;
      default:       return CHAR_SLASH;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- rtl/b64e_front.sv -----
// Front end: tracks group position and leftover bits, builds the characters for each byte.
`default_nettype none

module b64e_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire b64e_pkg::in_item_t item,
  output b64e_pkg::job_t        job
);

  b64e_pkg::phase_t phase, phase_next;
  logic [3:0]       carry, carry_next;

  logic [7:0] b;
  logic       last;

  assign b    = item.data_byte;
  assign last = item.last_byte;

  // Next group position and carried bits
  always_comb begin
    phase_next = phase;
    carry_next = carry;
    if (accept) begin
      case (phase)
        b64e_pkg::PH_ONE: begin
          phase_next = b64e_pkg::PH_TWO;
          carry_next = b[3:0];
        end
        b64e_pkg::PH_TWO: begin
          phase_next = b64e_pkg::PH_START;
          carry_next = 4'd0;
        end
        default: begin
          phase_next = b64e_pkg::PH_ONE;
          carry_next = {2'b00, b[1:0]};
        end
      endcase
      if (last) begin
        phase_next = b64e_pkg::PH_START;
        carry_next = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= b64e_pkg::PH_START;
      carry <= 4'd0;
    end else begin
      phase <= phase_next;
      carry <= carry_next;
    end
  end

  // Characters produced by the current byte
  always_comb begin
    job.chars    = {b64e_pkg::JOB_CHARS{b64e_pkg::PAD_CHAR}};
    job.last_idx = 2'd0;
    job.end_flag = 1'b0;
    case (phase)
      b64e_pkg::PH_ONE: begin
        job.chars[0] = b64e_pkg::sextet_char({carry[1:0], b[7:4]});
        if (last) begin
          job.chars[1] = b64e_pkg::sextet_char({b[3:0], 2'b00});
          job.last_idx = 2'd2;
          job.end_flag = 1'b1;
        end
      end
      b64e_pkg::PH_TWO: begin
        job.chars[0] = b64e_pkg::sextet_char({carry[3:0], b[7:6]});
        job.chars[1] = b64e_pkg::sextet_char(b[5:0]);
        job.last_idx = 2'd1;
        job.end_flag = last;
      end
      default: begin
        job.chars[0] = b64e_pkg::sextet_char(b[7:2]);
        if (last) begin
          job.chars[1] = b64e_pkg::sextet_char({b[1:0], 4'b0000});
          job.last_idx = 2'd3;
          job.end_flag = 1'b1;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/b64e_queue.sv -----
// Small job queue between front and back.
`default_nettype none

module b64e_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire b64e_pkg::job_t wr_data,
  output logic                full,
  input  wire logic           rd_en,
  output b64e_pkg::job_t      rd_data,
  output logic                empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  b64e_pkg::job_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  // Storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/b64e_back.sv -----
// Back end: holds one job and sends its characters out one per cycle while pop is asserted.
`default_nettype none

module b64e_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire b64e_pkg::job_t    q_data,
  output logic                   q_pop,
  output logic                   empty,
  input  wire logic              pop,
  output b64e_pkg::out_item_t    result
);

  b64e_pkg::job_t job;
  logic           valid;
  logic [1:0]     idx;
  logic           taken;
  logic           at_last;

  assign at_last = (idx == job.last_idx);
  assign taken   = valid && pop;
  // Load a new job when idle or when the final character leaves
  assign q_pop   = !q_empty && (!valid || (taken && at_last));

  assign empty              = !valid;
  assign result.out_char    = job.chars[idx];
  assign result.message_end = job.end_flag && at_last;

  // Job payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_data;
    end
  end

  // Occupancy and character index
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
    end else if (q_pop) begin
      valid <= 1'b1;
      idx   <= 2'd0;
    end else if (taken) begin
      if (at_last) begin
        valid <= 1'b0;
        idx   <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/base64_stream_encoder_core.sv -----
// Top level of the streaming Base64 encoder.
// Bytes go in through a push/full queue port and Base64 characters (A-Z a-z 0-9 + /,
// with '=' padding) come out through an empty/pop port, one character per pop;
// message_end marks the last character of each message. A byte is accepted in any
// cycle while the internal job queue (QUEUE_DEPTH entries) has room. When the block
// is idle, an accepted byte is written into the job queue and then loaded into the
// back end's job register; only then is its first character on the result port.
// Each byte yields one to four characters and the result port delivers one per cycle
// while pop is asserted, so the output side sets the sustained rate: inside a message
// 4 chars per 3 bytes, and a closing byte that needs two pads yields four characters.
`default_nettype none

module base64_stream_encoder_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire b64e_pkg::in_item_t  item,
  output logic                     empty,
  input  wire logic                pop,
  output b64e_pkg::out_item_t      result
);

  logic           accept;
  b64e_pkg::job_t front_job;
  b64e_pkg::job_t q_data;
  logic           q_empty;
  logic           q_pop;

  assign accept = push && !full;

  b64e_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .job    (front_job)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (front_job),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  b64e_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

`default_nettype wire

// ----- rtl/b64e_checker.sv -----
// Port-level checks for the Base64 encoder, bound to the top level.
`default_nettype none

module b64e_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                push,
  input wire logic                full,
  input wire logic                empty,
  input wire logic                pop,
  input wire b64e_pkg::out_item_t result
);

  // Reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("encoder not idle after reset");

  // A waiting result that is not taken stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result changed while stalled");

  // Every character shown is from the alphabet or a pad
  a_alphabet: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((result.out_char >= 8'h41 && result.out_char <= 8'h5A) ||
                (result.out_char >= 8'h61 && result.out_char <= 8'h7A) ||
                (result.out_char >= 8'h30 && result.out_char <= 8'h39) ||
                result.out_char == 8'h2B || result.out_char == 8'h2F ||
                result.out_char == 8'h3D))
    else $error("character outside the Base64 set");

  // A request taken while idle shows a character once it has passed the queue and the back-end job register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (push && !full && empty) |=> ##1 !empty)
    else $error("accepted byte produced no character");

endmodule

bind base64_stream_encoder_core b64e_checker u_b64e_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

`default_nettype wire
